// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the escaper RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define JSE_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define JSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define JSE_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define JSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/core/jse_pkg.sv =====
// Shared types and constants of the JSON string escaper.
package jse_pkg;

    localparam int MAX_BYTES = 12;
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);
    localparam int CP_W      = 21;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic CFG_ESCAPE_NON_ASCII  = 1'b0;
    localparam logic CFG_ESCAPE_APOSTROPHE = 1'b1;

    typedef struct packed {
        logic [CNT_W-1:0]                count;
        logic [MAX_BYTES-1:0][7:0]       bytes;
    } plan_t;

endpackage

// ===== rtl/core/jse_front.sv =====
// Front end: accepts code points and builds the byte plan for each.
module jse_front
    import jse_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_wr_en,
    input  logic            cfg_index,
    input  logic            cfg_data,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [23:0]     s_tdata,
    output logic            plan_valid,
    input  logic            plan_ready,
    output plan_t           plan
);

    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        logic [7:0] r;
        if (d < 4'd10)
        begin
            r = 8'h30 + {4'h0, d};
        end
        else
        begin
            r = 8'h57 + {4'h0, d};
        end
        return r;
    endfunction

    function automatic logic [5:0][7:0] word_bytes(input logic [15:0] w);
        logic [5:0][7:0] r;
        r[0] = CH_BSLASH;
        r[1] = CH_U;
        r[2] = hex_char(w[15:12]);
        r[3] = hex_char(w[11:8]);
        r[4] = hex_char(w[7:4]);
        r[5] = hex_char(w[3:0]);
        return r;
    endfunction

    logic            esc_non_ascii_reg;
    logic            esc_apos_reg;
    logic            valid_reg;
    logic            valid_next;
    plan_t           plan_reg;
    plan_t           plan_next;
    plan_t           cls;
    logic [CP_W-1:0] cp;
    logic [CP_W-1:0] v;
    logic [15:0]     hi_word;
    logic [15:0]     lo_word;
    logic            accept;

    assign cp      = s_tdata[CP_W-1:0];
    assign v       = cp - 21'h010000;
    assign hi_word = 16'hD800 + {5'b0, v[20:10]};
    assign lo_word = {6'b110111, v[9:0]};

    always_comb
    begin
        cls       = '0;
        cls.count = CNT_W'(1);
        if ((cp inside {[21'd32:21'd127]}) && cp != {13'b0, CH_QUOTE}
            && cp != {13'b0, CH_BSLASH} && cp != {13'b0, CH_APOS})
        begin
            cls.bytes[0] = cp[7:0];
        end
        else if (cp > 21'd127 && !esc_non_ascii_reg)
        begin
            if (cp < 21'h000800)
            begin
                cls.bytes[0] = {3'b110, cp[10:6]};
                cls.bytes[1] = {2'b10, cp[5:0]};
                cls.count    = CNT_W'(2);
            end
            else if (cp < 21'h010000)
            begin
                cls.bytes[0] = {4'hE, cp[15:12]};
                cls.bytes[1] = {2'b10, cp[11:6]};
                cls.bytes[2] = {2'b10, cp[5:0]};
                cls.count    = CNT_W'(3);
            end
            else
            begin
                cls.bytes[0] = {5'b11110, cp[20:18]};
                cls.bytes[1] = {2'b10, cp[17:12]};
                cls.bytes[2] = {2'b10, cp[11:6]};
                cls.bytes[3] = {2'b10, cp[5:0]};
                cls.count    = CNT_W'(4);
            end
        end
        else if (cp == {13'b0, CH_QUOTE} || cp == {13'b0, CH_BSLASH})
        begin
            cls.bytes[0] = CH_BSLASH;
            cls.bytes[1] = cp[7:0];
            cls.count    = CNT_W'(2);
        end
        else if (cp inside {21'd8, 21'd9, 21'd10, 21'd12, 21'd13})
        begin
            cls.bytes[0] = CH_BSLASH;
            cls.count    = CNT_W'(2);
            case (cp[3:0])
                4'd8:    cls.bytes[1] = CH_B;
                4'd9:    cls.bytes[1] = CH_T;
                4'd10:   cls.bytes[1] = CH_N;
                4'd12:   cls.bytes[1] = CH_F;
                default: cls.bytes[1] = CH_R;
            endcase
        end
        else if (cp == {13'b0, CH_APOS})
        begin
            if (esc_apos_reg)
            begin
                cls.bytes[0] = CH_BSLASH;
                cls.bytes[1] = CH_APOS;
                cls.count    = CNT_W'(2);
            end
            else
            begin
                cls.bytes[0] = CH_APOS;
            end
        end
        else if (cp <= 21'h00FFFF)
        begin
            cls.bytes[5:0] = word_bytes(cp[15:0]);
            cls.count      = CNT_W'(6);
        end
        else
        begin
            cls.bytes[5:0]  = word_bytes(hi_word);
            cls.bytes[11:6] = word_bytes(lo_word);
            cls.count       = CNT_W'(12);
        end
    end

    assign s_tready = !valid_reg || plan_ready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        plan_next  = plan_reg;
        if (accept)
        begin
            valid_next = 1'b1;
            plan_next  = cls;
        end
        else if (plan_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg         <= 1'b0;
            esc_non_ascii_reg <= 1'b0;
            esc_apos_reg      <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (cfg_wr_en && cfg_index == CFG_ESCAPE_NON_ASCII)
            begin
                esc_non_ascii_reg <= cfg_data;
            end
            if (cfg_wr_en && cfg_index == CFG_ESCAPE_APOSTROPHE)
            begin
                esc_apos_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        plan_reg <= plan_next;
    end

    assign plan_valid = valid_reg;
    assign plan       = plan_reg;

endmodule

// ===== rtl/core/jse_queue.sv =====
// Short plan queue between front and back ends.
module jse_queue
    import jse_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  plan_t   in_plan,
    output logic    out_valid,
    input  logic    out_ready,
    output plan_t   out_plan
);

    plan_t              mem [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               push;
    logic               pop;

    assign in_ready  = count_reg != QCNT_W'(QDEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_plan  = mem[rd_ptr_reg];

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        if (p == QPTR_W'(QDEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + QPTR_W'(1);
        end
        return r;
    endfunction

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_plan;
        end
    end

endmodule

// ===== rtl/core/jse_back.sv =====
// Back end: walks each plan and emits one byte per cycle while m_tready is high.
module jse_back
    import jse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        plan_valid,
    output logic        plan_pop,
    input  plan_t       plan,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic        m_tlast
);

    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    logic             ov_reg;
    logic             ov_next;
    logic [7:0]       byte_reg;
    logic             last_reg;
    logic             load;
    logic             is_last;

    assign load     = plan_valid && (!ov_reg || m_tready);
    assign is_last  = idx_reg == plan.count - CNT_W'(1);
    assign plan_pop = load && is_last;

    always_comb
    begin
        idx_next = idx_reg;
        ov_next  = ov_reg;
        if (load)
        begin
            ov_next  = 1'b1;
            idx_next = is_last ? '0 : idx_reg + CNT_W'(1);
        end
        else if (m_tready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= plan.bytes[idx_reg];
            last_reg <= is_last;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = byte_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== rtl/core/json_string_escaper_top.sv =====
// Top level of the JSON string escaper.
//
//  channel   direction  payload
//  s_*       in         tdata[20:0] code_point
//  m_*       out        tdata[7:0] out_byte, tlast last_byte
//  cfg_*     in         index 0 escape_non_ascii, index 1 escape_apostrophe
//
// One output byte per cycle while m_tready is high; a code point yields 1 to 12
// bytes, so input rate is one item per cycle for single-byte code points, and
// the back-end byte walker sets the pace for escapes and UTF-8 sequences.
// An accepted item passes the front-end plan register and a queue entry before its first byte is registered.
// Reset clears the valid flags, config, queue pointers and count and output index; data registers are not reset.
// Stalls on m_tready fill the two-entry queue, then back-pressure s_tready.
`include "assert_macros.svh"
module json_string_escaper_top
    import jse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic        cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [20:0] code_point, [23:21] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast
);

    logic   fe_valid;
    logic   q_in_ready;
    plan_t  fe_plan;
    logic   q_out_valid;
    logic   q_pop;
    plan_t  q_head;

    jse_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .plan_valid (fe_valid),
        .plan_ready (q_in_ready),
        .plan       (fe_plan)
    );

    jse_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fe_valid),
        .in_ready  (q_in_ready),
        .in_plan   (fe_plan),
        .out_valid (q_out_valid),
        .out_ready (q_pop),
        .out_plan  (q_head)
    );

    jse_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .plan_valid (q_out_valid),
        .plan_pop   (q_pop),
        .plan       (q_head),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    `JSE_ASSERT_NEXT(a_push_not_lost, clk, rst_n, fe_valid && q_in_ready, q_out_valid)
    `JSE_ASSERT_ALWAYS(a_plan_count, clk, rst_n, !q_out_valid || (q_head.count != '0 && q_head.count <= CNT_W'(MAX_BYTES)))
    `JSE_ASSERT_NEXT(a_pop_marks_last, clk, rst_n, q_pop, m_tvalid && m_tlast)

endmodule

// ===== verif/tb.sv =====
// Testbench of the JSON string escaper: predicted bytes checked against the stream output.
class escape_checker;
    typedef struct {
        logic [7:0] data;
        logic       last;
    } out_byte_t;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_U  = 8'h75;

    bit        non_ascii;
    bit        apostrophe;
    out_byte_t pending_bytes[$];
    int        errors;
    int        code_points;
    int        bytes_seen;

    function new();
        non_ascii   = 1'b0;
        apostrophe  = 1'b0;
        errors      = 0;
        code_points = 0;
        bytes_seen  = 0;
    endfunction

    task report(string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    function logic [7:0] hex_char(logic [3:0] d);
        return (d < 4'd10) ? 8'h30 + d : 8'h61 + d - 4'd10;
    endfunction

    function void push_word(ref logic [7:0] seq[$], input logic [15:0] word);
        seq.push_back(CH_BSLASH);
        seq.push_back(CH_LOW_U);
        seq.push_back(hex_char(word[15:12]));
        seq.push_back(hex_char(word[11:8]));
        seq.push_back(hex_char(word[7:4]));
        seq.push_back(hex_char(word[3:0]));
    endfunction

    function void push_utf8(ref logic [7:0] seq[$], input logic [20:0] cp);
        if (cp < 21'h800) begin
            seq.push_back(8'hC0 | cp[10:6]);
            seq.push_back(8'h80 | cp[5:0]);
        end else if (cp < 21'h10000) begin
            seq.push_back(8'hE0 | cp[15:12]);
            seq.push_back(8'h80 | cp[11:6]);
            seq.push_back(8'h80 | cp[5:0]);
        end else begin
            seq.push_back(8'hF0 | cp[20:18]);
            seq.push_back(8'h80 | cp[17:12]);
            seq.push_back(8'h80 | cp[11:6]);
            seq.push_back(8'h80 | cp[5:0]);
        end
    endfunction

    function void note_code_point(logic [20:0] cp);
        logic [7:0]  seq[$];
        int unsigned v;
        out_byte_t   ent;
        code_points++;
        if (cp >= 21'd32 && cp <= 21'd127 && cp != CH_QUOTE && cp != CH_BSLASH
            && cp != CH_APOS) begin
            seq.push_back(cp[7:0]);
        end else if (cp > 21'd127 && !non_ascii) begin
            push_utf8(seq, cp);
        end else if (cp == CH_QUOTE || cp == CH_BSLASH) begin
            seq.push_back(CH_BSLASH);
            seq.push_back(cp[7:0]);
        end else if (cp == 21'd8 || cp == 21'd12 || cp == 21'd10 || cp == 21'd13
                     || cp == 21'd9) begin
            seq.push_back(CH_BSLASH);
            case (cp[3:0])
                4'd8:    seq.push_back(8'h62);
                4'd12:   seq.push_back(8'h66);
                4'd10:   seq.push_back(8'h6E);
                4'd13:   seq.push_back(8'h72);
                default: seq.push_back(8'h74);
            endcase
        end else if (cp == CH_APOS) begin
            if (apostrophe)
                seq.push_back(CH_BSLASH);
            seq.push_back(CH_APOS);
        end else if (cp <= 21'hFFFF) begin
            push_word(seq, cp[15:0]);
        end else begin
            v = cp - 21'h10000;
            push_word(seq, 16'hD800 + 16'(v >> 10));
            push_word(seq, 16'hDC00 + 16'(v & 32'h3FF));
        end
        foreach (seq[i]) begin
            ent.data = seq[i];
            ent.last = (i == seq.size() - 1);
            pending_bytes.push_back(ent);
        end
    endfunction

    task check_byte(logic [7:0] data, logic last);
        out_byte_t ent;
        bytes_seen++;
        if (pending_bytes.size() == 0) begin
            report($sformatf("unexpected byte %02h last %0b", data, last));
        end else begin
            ent = pending_bytes.pop_front();
            if (data !== ent.data)
                report($sformatf("byte %02h, want %02h", data, ent.data));
            if (last !== ent.last)
                report($sformatf("last %0b on byte %02h, want %0b", last, data, ent.last));
        end
    endtask
endclass

module tb;
    import jse_pkg::*;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_index = 1'b0;
    logic        cfg_data  = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;   // [20:0] code_point, [23:21] zero
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;          // [7:0] out_byte
    logic        m_tlast;

    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            settings_used = 0;
    escape_checker sb;

    logic [20:0] directed_cps[$] = '{
        21'h00, 21'h08, 21'h09, 21'h0A, 21'h0C, 21'h0D, 21'h1F, 21'h20,
        21'h22, 21'h27, 21'h5C, 21'h7F, 21'h80, 21'h7FF, 21'h800, 21'hD800,
        21'hDFFF, 21'hFFFF, 21'h10000, 21'h10FFFF, 21'h110000, 21'h1FFFFF
    };

    json_string_escaper_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_code_point(s_tdata[20:0]);
        if (rst_n && m_tvalid && m_tready)
            sb.check_byte(m_tdata, m_tlast);
    end

    function automatic logic [20:0] rand_code_point();
        case ($urandom_range(7))
            0: return 21'($urandom_range(127, 32));
            1: return 21'($urandom_range(31, 0));
            2: case ($urandom_range(7))
                   0: return 21'h22;
                   1: return 21'h5C;
                   2: return 21'h27;
                   3: return 21'h08;
                   4: return 21'h09;
                   5: return 21'h0A;
                   6: return 21'h0C;
                   default: return 21'h0D;
               endcase
            3: return 21'($urandom_range(21'h7FF, 21'h80));
            4: return 21'($urandom_range(21'hFFFF, 21'h800));
            5: return 21'($urandom_range(21'h10FFFF, 21'h10000));
            6: return 21'($urandom_range(21'h1FFFFF, 21'h110000));
            default: return 21'($urandom);
        endcase
    endfunction

    task send_code_point(logic [20:0] cp);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, cp};
        do @(posedge clk); while (!s_tready);
    endtask

    task send_random(int count);
        repeat (count) send_code_point(rand_code_point());
    endtask

    task drain();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (sb.pending_bytes.size() != 0 && waited < 50000) begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
        if (sb.pending_bytes.size() != 0) begin
            sb.report($sformatf("%0d bytes never arrived", sb.pending_bytes.size()));
            sb.pending_bytes.delete();
        end
    endtask

    task write_cfg(logic non_ascii, logic apostrophe);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_ESCAPE_NON_ASCII;
        cfg_data  <= non_ascii;
        @(posedge clk);
        cfg_index <= CFG_ESCAPE_APOSTROPHE;
        cfg_data  <= apostrophe;
        @(posedge clk);
        cfg_wr_en     <= 1'b0;
        sb.non_ascii  = non_ascii;
        sb.apostrophe = apostrophe;
        settings_used++;
        @(posedge clk);
    endtask

    initial
    begin
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 13;
        recv_idle_pct = 46;
        settings_used = 1;
        foreach (directed_cps[i]) send_code_point(directed_cps[i]);
        drain();
        write_cfg(1'b1, 1'b1);
        send_random(97);
        drain();

        send_idle_pct = 46;
        recv_idle_pct = 13;
        write_cfg(1'b1, 1'b0);
        send_random(97);
        drain();
        write_cfg(1'b0, 1'b1);
        send_random(97);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_cfg(1'b0, 1'b0);
        send_random(97);
        drain();

        $display("escaped %0d code points into %0d bytes under %0d register settings",
                 sb.code_points, sb.bytes_seen, settings_used);
        $display("covered controls, quotes, UTF-8 of all lengths, \\u words and pairs");
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #400000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ===== json_string_escaper_top.f =====
+incdir+rtl/core
rtl/core/jse_pkg.sv
rtl/core/jse_front.sv
rtl/core/jse_queue.sv
rtl/core/jse_back.sv
rtl/core/json_string_escaper_top.sv
verif/tb.sv
